// ===== src/kfts_pkg.sv =====
// Shared types, register codes and the step program of the two-state Kalman filter.
package kfts_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_WIDTH       = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_VAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_P_POS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_P_VEL  = 3'd7;

    localparam logic signed [IO_WIDTH-1:0] RST_TRANS_GAIN  = 32'sd32768;
    localparam logic signed [IO_WIDTH-1:0] RST_CTRL_GAIN   = 32'sd32768;
    localparam logic signed [IO_WIDTH-1:0] RST_PROCESS_VAR = 32'sd6554;
    localparam logic signed [IO_WIDTH-1:0] RST_MEAS_VAR    = 32'sd3277;
    localparam logic signed [IO_WIDTH-1:0] RST_INIT_POS    = 32'sd0;
    localparam logic signed [IO_WIDTH-1:0] RST_INIT_VEL    = 32'sd327680;
    localparam logic signed [IO_WIDTH-1:0] RST_INIT_P_POS  = 32'sd655;
    localparam logic signed [IO_WIDTH-1:0] RST_INIT_P_VEL  = 32'sd65536;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] measurement;
        logic signed [IO_WIDTH-1:0] control;
    } in_t;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] pos_est;
        logic signed [IO_WIDTH-1:0] vel_est;
        logic signed [IO_WIDTH-1:0] innovation;
        logic                       degenerate;
    } out_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [4:0] {
        S_POS, S_VEL, S_PP, S_PV, S_VV,
        S_MEAS, S_CTL, S_DT, S_G, S_Q, S_R,
        S_T, S_POSP, S_VELP, S_B, S_PPP, S_VVP, S_S,
        S_K0, S_K1, S_INN
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t src_a;
        sel_t src_b;
        sel_t dst;
    } step_t;

    typedef struct packed {
        logic  start;
        logic  load_in;
        logic  load_out;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    localparam int NUM_STEPS = 26;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    function automatic step_t prog(input logic [STEP_W-1:0] idx);
        step_t s;
        case (idx)
            5'd0:    s = '{OP_MUL, S_DT,   S_VEL,  S_T};
            5'd1:    s = '{OP_ADD, S_POS,  S_T,    S_POSP};
            5'd2:    s = '{OP_MUL, S_G,    S_CTL,  S_T};
            5'd3:    s = '{OP_ADD, S_VEL,  S_T,    S_VELP};
            5'd4:    s = '{OP_MUL, S_DT,   S_VV,   S_T};
            5'd5:    s = '{OP_ADD, S_PV,   S_T,    S_B};
            5'd6:    s = '{OP_MUL, S_DT,   S_PV,   S_T};
            5'd7:    s = '{OP_ADD, S_PP,   S_T,    S_PPP};
            5'd8:    s = '{OP_MUL, S_DT,   S_B,    S_T};
            5'd9:    s = '{OP_ADD, S_PPP,  S_T,    S_PPP};
            5'd10:   s = '{OP_ADD, S_PPP,  S_Q,    S_PPP};
            5'd11:   s = '{OP_ADD, S_VV,   S_Q,    S_VVP};
            5'd12:   s = '{OP_ADD, S_PPP,  S_R,    S_S};
            5'd13:   s = '{OP_DIV, S_PPP,  S_S,    S_K0};
            5'd14:   s = '{OP_DIV, S_B,    S_S,    S_K1};
            5'd15:   s = '{OP_SUB, S_MEAS, S_POSP, S_INN};
            5'd16:   s = '{OP_MUL, S_K0,   S_INN,  S_T};
            5'd17:   s = '{OP_ADD, S_POSP, S_T,    S_POS};
            5'd18:   s = '{OP_MUL, S_K1,   S_INN,  S_T};
            5'd19:   s = '{OP_ADD, S_VELP, S_T,    S_VEL};
            5'd20:   s = '{OP_MUL, S_K0,   S_PPP,  S_T};
            5'd21:   s = '{OP_SUB, S_PPP,  S_T,    S_PP};
            5'd22:   s = '{OP_MUL, S_K0,   S_B,    S_T};
            5'd23:   s = '{OP_SUB, S_B,    S_T,    S_PV};
            5'd24:   s = '{OP_MUL, S_K1,   S_B,    S_T};
            5'd25:   s = '{OP_SUB, S_VVP,  S_T,    S_VV};
            default: s = '{OP_ADD, S_T,    S_T,    S_T};
        endcase
        return s;
    endfunction

endpackage

// ===== src/kfts_ctrl.sv =====
// Sequencer that walks the filter step program and runs both handshakes.
module kfts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              meas_valid,
    output logic              meas_stall,
    output logic              est_valid,
    input  logic              est_stall,
    input  kfts_pkg::status_t status,
    output kfts_pkg::cmd_t    cmd
);
    import kfts_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ISSUE,
        C_WAIT,
        C_DONE
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                est_valid_reg;
    logic                accept;
    logic                deliver;

    assign accept  = (state_reg == C_IDLE) && meas_valid;
    assign deliver = (state_reg == C_DONE) && (!est_valid_reg || !est_stall);

    assign meas_stall   = (state_reg != C_IDLE);
    assign est_valid    = est_valid_reg;
    assign cmd.start    = (state_reg == C_ISSUE);
    assign cmd.load_in  = accept;
    assign cmd.load_out = deliver;
    assign cmd.step     = prog(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            step_reg      <= '0;
            est_valid_reg <= 1'b0;
        end
        else
        begin
            if (deliver)
            begin
                est_valid_reg <= 1'b1;
            end
            else if (est_valid_reg && !est_stall)
            begin
                est_valid_reg <= 1'b0;
            end
            case (state_reg)
                C_IDLE:
                begin
                    if (accept)
                    begin
                        step_reg  <= '0;
                        state_reg <= C_ISSUE;
                    end
                end
                C_ISSUE:
                begin
                    state_reg <= C_WAIT;
                end
                C_WAIT:
                begin
                    if (status.done)
                    begin
                        if (step_reg == STEP_W'(NUM_STEPS - 1))
                        begin
                            state_reg <= C_DONE;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= C_ISSUE;
                        end
                    end
                end
                C_DONE:
                begin
                    // hold the finished request until the output register is free
                    if (deliver)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/kfts_dp.sv =====
// Datapath: filter state, configuration, one shared multiply/divide/add unit.
module kfts_dp #(
    parameter int DATA_WIDTH = kfts_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kfts_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kfts_pkg::cmd_t                      cmd,
    output kfts_pkg::status_t                   status,
    input  kfts_pkg::in_t                       meas_data,
    output kfts_pkg::out_t                      est_data,
    input  logic                                wr_en,
    input  logic [kfts_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [kfts_pkg::IO_WIDTH-1:0]       wr_data
);
    import kfts_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DIG  = 16;
    localparam int NDIG = (W + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int PW   = W + BW;
    localparam int DW   = W + F;
    localparam int CW   = $clog2(DW + 1);

    localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_FIN
    } fu_state_t;

    function automatic logic signed [W-1:0] to_w(input logic signed [IO_WIDTH-1:0] v);
        logic signed [IO_WIDTH-1:0] hi;
        hi = v >>> (W - 1);
        if (hi == '0 || hi == '1)
        begin
            return W'(v);
        end
        return v[IO_WIDTH-1] ? MINW : MAXW;
    endfunction

    function automatic logic signed [IO_WIDTH-1:0] to_io(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi;
        hi = v >>> (IO_WIDTH - 1);
        if (hi == '0 || hi == '1)
        begin
            return IO_WIDTH'(v);
        end
        return v[W-1] ? {1'b1, {(IO_WIDTH-1){1'b0}}} : {1'b0, {(IO_WIDTH-1){1'b1}}};
    endfunction

    function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [W-1:0] mag,
                                                     input logic sat);
        if (sat)
        begin
            return neg ? MINW : MAXW;
        end
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    // configuration
    logic signed [W-1:0] dt_reg, g_reg, q_reg, r_reg;
    // filter state and temporaries
    logic signed [W-1:0] pos_reg, vel_reg, pp_reg, pv_reg, vv_reg;
    logic signed [W-1:0] meas_reg, ctl_reg;
    logic signed [W-1:0] t_reg, posp_reg, velp_reg, b_reg, ppp_reg, vvp_reg, s_reg;
    logic signed [W-1:0] k0_reg, k1_reg, inn_reg;
    out_t                out_reg;

    // shared unit
    fu_state_t           fu_state_reg;
    op_t                 op_reg;
    sel_t                dst_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic signed [W-1:0] a_reg, bop_reg;
    logic [W-1:0]        mag_a_reg, mag_d_reg;
    logic [BW-1:0]       mag_b_reg;
    logic [PW-1:0]       acc_reg;
    logic [DW-1:0]       dsr_reg, quo_reg;
    logic [W-1:0]        rem_reg;
    logic [CW-1:0]       cnt_reg;

    logic signed [W-1:0] op_a, op_b, res;
    logic [W:0]          rem_sh;
    logic [PW:0]         rnd;
    logic signed [W:0]   sum;
    logic signed [IO_WIDTH-1:0] wr_s, wr_u;

    assign wr_s = $signed(wr_data);
    assign wr_u = $signed({1'b0, wr_data[IO_WIDTH-2:0]});

    always_comb
    begin
        case (cmd.step.src_a)
            S_POS:   op_a = pos_reg;
            S_VEL:   op_a = vel_reg;
            S_PP:    op_a = pp_reg;
            S_PV:    op_a = pv_reg;
            S_VV:    op_a = vv_reg;
            S_MEAS:  op_a = meas_reg;
            S_CTL:   op_a = ctl_reg;
            S_DT:    op_a = dt_reg;
            S_G:     op_a = g_reg;
            S_Q:     op_a = q_reg;
            S_R:     op_a = r_reg;
            S_T:     op_a = t_reg;
            S_POSP:  op_a = posp_reg;
            S_VELP:  op_a = velp_reg;
            S_B:     op_a = b_reg;
            S_PPP:   op_a = ppp_reg;
            S_VVP:   op_a = vvp_reg;
            S_S:     op_a = s_reg;
            S_K0:    op_a = k0_reg;
            S_K1:    op_a = k1_reg;
            S_INN:   op_a = inn_reg;
            default: op_a = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.step.src_b)
            S_POS:   op_b = pos_reg;
            S_VEL:   op_b = vel_reg;
            S_PP:    op_b = pp_reg;
            S_PV:    op_b = pv_reg;
            S_VV:    op_b = vv_reg;
            S_MEAS:  op_b = meas_reg;
            S_CTL:   op_b = ctl_reg;
            S_DT:    op_b = dt_reg;
            S_G:     op_b = g_reg;
            S_Q:     op_b = q_reg;
            S_R:     op_b = r_reg;
            S_T:     op_b = t_reg;
            S_POSP:  op_b = posp_reg;
            S_VELP:  op_b = velp_reg;
            S_B:     op_b = b_reg;
            S_PPP:   op_b = ppp_reg;
            S_VVP:   op_b = vvp_reg;
            S_S:     op_b = s_reg;
            S_K0:    op_b = k0_reg;
            S_K1:    op_b = k1_reg;
            S_INN:   op_b = inn_reg;
            default: op_b = '0;
        endcase
    end

    assign rem_sh = {rem_reg, dsr_reg[DW-1]};
    assign rnd    = (PW+1)'(acc_reg) + ((PW+1)'(1) << (F - 1));
    assign sum    = (op_reg == OP_SUB) ? ((W+1)'(a_reg) - (W+1)'(bop_reg))
                                       : ((W+1)'(a_reg) + (W+1)'(bop_reg));

    always_comb
    begin
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                if (sum[W] != sum[W-1])
                begin
                    res = sum[W] ? MINW : MAXW;
                end
                else
                begin
                    res = sum[W-1:0];
                end
            end
            OP_MUL:  res = from_mag(neg_reg, W'(rnd >> F), |(rnd >> (F + W - 1)));
            OP_DIV:  res = zero_reg ? '0 : from_mag(neg_reg, W'(quo_reg), |(quo_reg >> (W - 1)));
            default: res = '0;
        endcase
    end

    assign status.done = (fu_state_reg == F_FIN);
    assign est_data    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fu_state_reg <= F_IDLE;
        end
        else
        begin
            case (fu_state_reg)
                F_IDLE:
                begin
                    if (cmd.start)
                    begin
                        case (cmd.step.op)
                            OP_MUL:  fu_state_reg <= F_MUL;
                            OP_DIV:  fu_state_reg <= (op_b == '0) ? F_FIN : F_DIV;
                            default: fu_state_reg <= F_FIN;
                        endcase
                    end
                end
                F_MUL:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        fu_state_reg <= F_FIN;
                    end
                end
                F_DIV:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        fu_state_reg <= F_FIN;
                    end
                end
                F_FIN:
                begin
                    fu_state_reg <= F_IDLE;
                end
                default:
                begin
                    fu_state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // unit payload
    always_ff @(posedge clk)
    begin
        case (fu_state_reg)
            F_IDLE:
            begin
                if (cmd.start)
                begin
                    op_reg    <= cmd.step.op;
                    dst_reg   <= cmd.step.dst;
                    a_reg     <= op_a;
                    bop_reg   <= op_b;
                    neg_reg   <= op_a[W-1] ^ op_b[W-1];
                    zero_reg  <= (op_b == '0);
                    mag_a_reg <= mag_of(op_a);
                    mag_d_reg <= mag_of(op_b);
                    mag_b_reg <= BW'(mag_of(op_b));
                    acc_reg   <= '0;
                    dsr_reg   <= {mag_of(op_a), {F{1'b0}}};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= (cmd.step.op == OP_MUL) ? CW'(NDIG) : CW'(DW);
                end
            end
            F_MUL:
            begin
                // one 16-bit digit of the multiplier per cycle, top digit first
                acc_reg   <= (acc_reg << DIG) + PW'(mag_a_reg * mag_b_reg[BW-1 -: DIG]);
                mag_b_reg <= mag_b_reg << DIG;
                cnt_reg   <= cnt_reg - 1'b1;
            end
            F_DIV:
            begin
                if (rem_sh >= {1'b0, mag_d_reg})
                begin
                    rem_reg <= W'(rem_sh - {1'b0, mag_d_reg});
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[W-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                dsr_reg <= dsr_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg   <= to_w(RST_TRANS_GAIN);
            g_reg    <= to_w(RST_CTRL_GAIN);
            q_reg    <= to_w(RST_PROCESS_VAR);
            r_reg    <= to_w(RST_MEAS_VAR);
            pos_reg  <= to_w(RST_INIT_POS);
            vel_reg  <= to_w(RST_INIT_VEL);
            pp_reg   <= to_w(RST_INIT_P_POS);
            pv_reg   <= '0;
            vv_reg   <= to_w(RST_INIT_P_VEL);
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_TRANS_GAIN:  dt_reg <= to_w(wr_s);
                    CFG_CTRL_GAIN:   g_reg  <= to_w(wr_s);
                    CFG_PROCESS_VAR: q_reg  <= to_w(wr_u);
                    CFG_MEAS_VAR:    r_reg  <= to_w(wr_u);
                    CFG_INIT_POS:
                    begin
                        pos_reg  <= to_w(wr_s);
                    end
                    CFG_INIT_VEL:
                    begin
                        vel_reg  <= to_w(wr_s);
                    end
                    CFG_INIT_P_POS:
                    begin
                        pp_reg  <= to_w(wr_u);
                        pv_reg  <= '0;
                    end
                    CFG_INIT_P_VEL:
                    begin
                        vv_reg  <= to_w(wr_u);
                        pv_reg  <= '0;
                    end
                    default:
                    begin
                        dt_reg <= dt_reg;
                    end
                endcase
            end
            else if (fu_state_reg == F_FIN)
            begin
                case (dst_reg)
                    S_POS:   pos_reg <= res;
                    S_VEL:   vel_reg <= res;
                    S_PP:    pp_reg  <= res;
                    S_PV:    pv_reg  <= res;
                    S_VV:    vv_reg  <= res;
                    default: pos_reg <= pos_reg;
                endcase
            end
        end
    end

    // temporaries and request payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            meas_reg <= to_w(meas_data.measurement);
            ctl_reg  <= to_w(meas_data.control);
        end
        if (fu_state_reg == F_FIN)
        begin
            case (dst_reg)
                S_T:     t_reg    <= res;
                S_POSP:  posp_reg <= res;
                S_VELP:  velp_reg <= res;
                S_B:     b_reg    <= res;
                S_PPP:   ppp_reg  <= res;
                S_VVP:   vvp_reg  <= res;
                S_S:     s_reg    <= res;
                S_K0:    k0_reg   <= res;
                S_K1:    k1_reg   <= res;
                S_INN:   inn_reg  <= res;
                default: t_reg    <= t_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            out_reg.pos_est    <= to_io(pos_reg);
            out_reg.vel_est    <= to_io(vel_reg);
            out_reg.innovation <= to_io(inn_reg);
            out_reg.degenerate <= (s_reg == '0);
        end
    end

endmodule

// ===== src/kalman_filter_two_state.sv =====
// Two-state Kalman filter: 10 multiplies (16-bit digit serial), 2 divides (bit-serial) and 14 adds
// per request on one shared unit; after the last step the result waits in the done state until
// the output register is free, then is registered there; one request at a time.
// Throughput is set by the shared multiply/divide unit and the bit-serial divide.
// Reset loads the configuration defaults and the initial state; the block is ready at once.
module kalman_filter_two_state #(
    parameter int DATA_WIDTH = kfts_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kfts_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           meas_valid,
    output logic                           meas_stall,
    input  kfts_pkg::in_t                  meas_data,
    output logic                           est_valid,
    input  logic                           est_stall,
    output kfts_pkg::out_t                 est_data,
    input  logic                           wr_en,
    input  logic [kfts_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [kfts_pkg::IO_WIDTH-1:0]  wr_data
);
    import kfts_pkg::*;

    cmd_t    cmd;
    status_t status;

    kfts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .est_valid  (est_valid),
        .est_stall  (est_stall),
        .status     (status),
        .cmd        (cmd)
    );

    kfts_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .meas_data (meas_data),
        .est_data  (est_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

endmodule
